// ===== hw/rtl/national_id_check_digit_validator_assert.svh =====
// ---------------------------------------------------------------------------
// National ID check digit validator - assertion macros
// Concurrent assertion wrappers; compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef NATIONAL_ID_CHECK_DIGIT_VALIDATOR_ASSERT_SVH
`define NATIONAL_ID_CHECK_DIGIT_VALIDATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define NIDCV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nidcv assertion failed");

// next-cycle implication
`define NIDCV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nidcv assertion failed");

`else

`define NIDCV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NIDCV_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/nidcv_pkg.sv =====
// ---------------------------------------------------------------------------
// nidcv_pkg
// Shared widths, types and helpers for the national ID check digit validator.
// ---------------------------------------------------------------------------
package nidcv_pkg;

  localparam int ID_W       = 37;
  localparam int DIGITS     = 11;
  localparam int DIG_W      = 4 * DIGITS;
  localparam int STAGE_BITS = 4;     // binary bits converted per pipeline stage

  localparam logic [ID_W-1:0] ID_MIN = ID_W'(64'd10000000000);
  localparam logic [ID_W-1:0] ID_MAX = ID_W'(64'd99999999999);

  typedef enum logic [1:0] {
    REASON_OK       = 2'd0,
    REASON_LENGTH   = 2'd1,
    REASON_TENTH    = 2'd2,
    REASON_ELEVENTH = 2'd3
  } reason_t;

  // payload carried alongside the shrinking binary word
  typedef struct packed {
    logic [DIG_W-1:0] bcd;
    logic             in_range;
  } pipe_t;

  // x mod 10 for x < 512: quotient by reciprocal (205/2048), exact below 1029
  function automatic logic [3:0] mod10(input logic [8:0] x);
    logic [17:0] prod;
    logic [6:0]  q;
    logic [8:0]  rem;
    prod = 18'(x) * 18'd205;
    q    = prod[17:11];
    rem  = x - 9'(q) * 9'd10;
    return rem[3:0];
  endfunction

endpackage

// ===== hw/rtl/national_id_check_digit_validator.sv =====
// ---------------------------------------------------------------------------
// national_id_check_digit_validator
// Checks eleven-digit national ID numbers: length and both check digits.
// ---------------------------------------------------------------------------
// Channel  Dir  Ports                     Contents
// in_      in   tvalid/tready/tdata[39:0]  id_number
// out_     out  tvalid/tready/tdata[15:0]  is_valid, fail_reason, expected digits
//
// One number per cycle sustained while the output is not stalled. The binary to
// BCD converter takes STAGE_BITS bits per stage over NUM_STAGES stages, then one
// stage sums digits and one reduces mod 10 and compares. A stalled output freezes
// the whole pipeline; in_tready is high whenever the output register is empty or
// being drained. Reset clears all valid bits.
// ---------------------------------------------------------------------------
`include "national_id_check_digit_validator_assert.svh"

module national_id_check_digit_validator
  import nidcv_pkg::*;
#(
  parameter int STAGE_BITS_P = STAGE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [36:0] id_number, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] is_valid, [2:1] fail_reason,
                                  // [6:3] expected_tenth, [10:7] expected_eleventh
);

  localparam int NUM_STAGES = (ID_W + STAGE_BITS_P - 1) / STAGE_BITS_P;
  localparam int PAD_W      = NUM_STAGES * STAGE_BITS_P;

  logic             ce;
  logic             vld_s  [0:NUM_STAGES];
  logic [PAD_W-1:0] bin_s  [0:NUM_STAGES];
  pipe_t            pipe_s [0:NUM_STAGES];

  logic [ID_W-1:0]  id_in;
  logic [DIG_W-1:0] bcd_fin;

  logic       sum_vld_r;
  logic       sum_range_r;
  logic [5:0] odd_r, even_r;
  logic [3:0] d10_r, d11_r;
  logic [5:0] odd_nxt, even_nxt;

  logic       out_vld_r;
  logic       is_valid_r;
  reason_t    reason_r;
  logic [3:0] exp10_r, exp11_r;
  logic [3:0] exp10_nxt, exp11_nxt;
  logic       is_valid_nxt;
  reason_t    reason_nxt;

  assign ce        = !out_vld_r || out_tready;
  assign in_tready = ce;

  // stage 0 feed: length check rides along with the conversion
  assign id_in              = in_tdata[ID_W-1:0];
  assign vld_s[0]           = in_tvalid;
  assign bin_s[0]           = PAD_W'(id_in);
  assign pipe_s[0].bcd      = '0;
  assign pipe_s[0].in_range = (id_in >= ID_MIN) && (id_in <= ID_MAX);

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
    nidcv_dabble #(
      .STEP_BITS (STAGE_BITS_P),
      .PAD_W     (PAD_W)
    ) u_dabble (
      .clk    (clk),
      .rst_n  (rst_n),
      .ce     (ce),
      .vld_i  (vld_s[g]),
      .bin_i  (bin_s[g]),
      .pipe_i (pipe_s[g]),
      .vld_o  (vld_s[g+1]),
      .bin_o  (bin_s[g+1]),
      .pipe_o (pipe_s[g+1])
    );
  end

  // digit 10 is the most significant (d1), digit 0 the last (d11)
  assign bcd_fin  = pipe_s[NUM_STAGES].bcd;
  assign odd_nxt  = 6'(bcd_fin[40 +: 4]) + 6'(bcd_fin[32 +: 4]) + 6'(bcd_fin[24 +: 4])
                  + 6'(bcd_fin[16 +: 4]) + 6'(bcd_fin[8 +: 4]);
  assign even_nxt = 6'(bcd_fin[36 +: 4]) + 6'(bcd_fin[28 +: 4]) + 6'(bcd_fin[20 +: 4])
                  + 6'(bcd_fin[12 +: 4]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (ce) begin
      sum_vld_r <= vld_s[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sum_range_r <= pipe_s[NUM_STAGES].in_range;
      odd_r       <= odd_nxt;
      even_r      <= even_nxt;
      d10_r       <= bcd_fin[4 +: 4];
      d11_r       <= bcd_fin[0 +: 4];
    end
  end

  // +40 keeps 7*odd - even non-negative without changing the residue
  always_comb begin
    exp10_nxt = mod10(9'(odd_r) * 9'd7 + 9'd40 - 9'(even_r));
    exp11_nxt = mod10(9'(odd_r) + 9'(even_r) + 9'(d10_r));
    if (!sum_range_r) begin
      is_valid_nxt = 1'b0;
      reason_nxt   = REASON_LENGTH;
      exp10_nxt    = '0;
      exp11_nxt    = '0;
    end else if (exp10_nxt != d10_r) begin
      is_valid_nxt = 1'b0;
      reason_nxt   = REASON_TENTH;
    end else if (exp11_nxt != d11_r) begin
      is_valid_nxt = 1'b0;
      reason_nxt   = REASON_ELEVENTH;
    end else begin
      is_valid_nxt = 1'b1;
      reason_nxt   = REASON_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= sum_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      is_valid_r <= is_valid_nxt;
      reason_r   <= reason_nxt;
      exp10_r    <= exp10_nxt;
      exp11_r    <= exp11_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, exp11_r, exp10_r, reason_r, is_valid_r};

  `NIDCV_ASSERT_IMP(a_valid_ok, clk, rst_n, out_vld_r && is_valid_r, reason_r == REASON_OK)
  `NIDCV_ASSERT_IMP(a_len_zero, clk, rst_n, out_vld_r && reason_r == REASON_LENGTH,
                    exp10_r == 4'd0 && exp11_r == 4'd0)
  `NIDCV_ASSERT_IMP(a_digits, clk, rst_n, out_vld_r, exp10_r <= 4'd9 && exp11_r <= 4'd9)
  `NIDCV_ASSERT_NXT(a_stall_hold, clk, rst_n, sum_vld_r && out_vld_r && !out_tready,
                    sum_vld_r && out_vld_r)

endmodule

// ===== hw/rtl/nidcv_dabble.sv =====
// ---------------------------------------------------------------------------
// nidcv_dabble
// One registered shift-and-add-3 stage of the binary to BCD converter.
// ---------------------------------------------------------------------------
module nidcv_dabble
  import nidcv_pkg::*;
#(
  parameter int STEP_BITS = STAGE_BITS,
  parameter int PAD_W     = STAGE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ce,
  input  logic             vld_i,
  input  logic [PAD_W-1:0] bin_i,
  input  pipe_t            pipe_i,
  output logic             vld_o,
  output logic [PAD_W-1:0] bin_o,
  output pipe_t            pipe_o
);

  logic             vld_r;
  logic [PAD_W-1:0] bin_r;
  pipe_t            pipe_r;
  logic [DIG_W-1:0] bcd_nxt;
  logic [PAD_W-1:0] bin_nxt;

  always_comb begin
    bcd_nxt = pipe_i.bcd;
    bin_nxt = bin_i;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int j = 0; j < DIGITS; j++) begin
        if (bcd_nxt[4*j +: 4] >= 4'd5) begin
          bcd_nxt[4*j +: 4] = bcd_nxt[4*j +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[DIG_W-2:0], bin_nxt[PAD_W-1]};
      bin_nxt = {bin_nxt[PAD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ce) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      bin_r           <= bin_nxt;
      pipe_r.bcd      <= bcd_nxt;
      pipe_r.in_range <= pipe_i.in_range;
    end
  end

  assign vld_o  = vld_r;
  assign bin_o  = bin_r;
  assign pipe_o = pipe_r;

endmodule
